### hdl/jsud_pkg.sv
// Shared types and constants for the JSON string unescape decoder.
// Used by jsud_front, jsud_fifo, jsud_back and the top level.
package jsud_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    localparam int unsigned MAX_RESULTS     = 4;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Results of one request: data[0..last_idx], all bytes except the
    // final entry, whose kind is tail_kind.
    typedef struct packed {
        logic [1:0]                   last_idx;
        logic [MAX_RESULTS-1:0][7:0]  data;
        t_kind                        tail_kind;
    } t_group;

endpackage

### hdl/jsud_front.sv
// Front end: literal scanner, escape and hex decoding, UTF-8 encoding.
// Turns a request into at most one result group. Depends on jsud_pkg.
module jsud_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_text_end,
    input  logic              i_space,
    output logic              o_push,
    output jsud_pkg::t_group  o_group
);
    import jsud_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [5:0] HI_TAG   = 6'b110110;
    localparam logic [5:0] LO_TAG   = 6'b110111;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STR,
        S_ESC,
        S_HEX1,
        S_AFT_HI,
        S_AFT_HI_BS,
        S_HEX2
    } t_mode;

    typedef struct packed {
        logic [2:0]                   n;
        logic [MAX_RESULTS-1:0][7:0]  b;
    } t_enc;

    function automatic t_enc enc16(input logic [15:0] code);
        t_enc e;
        e = '0;
        if (code < 16'h0080) begin
            e.n    = 3'd1;
            e.b[0] = code[7:0];
        end else if (code < 16'h0800) begin
            e.n    = 3'd2;
            e.b[0] = {3'b110, code[10:6]};
            e.b[1] = {2'b10, code[5:0]};
        end else begin
            e.n    = 3'd3;
            e.b[0] = {4'b1110, code[15:12]};
            e.b[1] = {2'b10, code[11:6]};
            e.b[2] = {2'b10, code[5:0]};
        end
        return e;
    endfunction

    function automatic t_enc enc_pair(input logic [9:0] hi, input logic [9:0] lo);
        t_enc       e;
        logic [4:0] plane;
        plane  = {1'b0, hi[9:6]} + 5'd1;
        e.n    = 3'd4;
        e.b[0] = {5'b11110, plane[4:2]};
        e.b[1] = {2'b10, plane[1:0], hi[5:2]};
        e.b[2] = {2'b10, hi[1:0], lo[9:6]};
        e.b[3] = {2'b10, lo[5:0]};
        return e;
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [8:0] esc_val(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = '0;
        endcase
        return r;
    endfunction

    t_mode       r_mode, n_mode;
    logic [11:0] r_hex, n_hex;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_high, n_high;

    logic        accept;
    logic [4:0]  dig;
    logic [8:0]  esc;
    logic [15:0] code;
    logic [15:0] hi_code;
    logic        is_ws;
    t_enc        enc;
    logic        tail_en;
    t_kind       tkind;
    logic [7:0]  tbyte;
    logic [2:0]  total;

    assign o_in_ready = i_space;
    assign accept     = i_in_valid && i_space;
    assign dig        = hex_val(i_in_byte);
    assign esc        = esc_val(i_in_byte);
    assign code       = {r_hex, dig[3:0]};
    assign hi_code    = {HI_TAG, r_high};
    assign is_ws      = (i_in_byte == 8'h20) || (i_in_byte inside {[8'h09:8'h0D]});

    always_comb begin
        n_mode  = r_mode;
        n_hex   = r_hex;
        n_cnt   = r_cnt;
        n_high  = r_high;
        enc     = '0;
        tail_en = 1'b0;
        tkind   = KIND_BYTE;
        tbyte   = '0;
        case (r_mode)
            S_IDLE: begin
                if (i_in_byte == CH_QUOTE) begin
                    n_mode = S_STR;
                end else if (!is_ws) begin
                    tail_en = 1'b1;
                    tkind   = KIND_ERR;
                end
            end
            S_STR, S_AFT_HI: begin
                if (r_mode == S_AFT_HI && i_in_byte == CH_BSL) begin
                    n_mode = S_AFT_HI_BS;
                end else begin
                    if (r_mode == S_AFT_HI) begin
                        enc    = enc16(hi_code);
                        n_mode = S_STR;
                    end
                    if (i_in_byte == CH_QUOTE) begin
                        tail_en = 1'b1;
                        tkind   = KIND_DONE;
                        n_mode  = S_IDLE;
                    end else if (i_in_byte == CH_BSL) begin
                        n_mode = S_ESC;
                    end else begin
                        tail_en = 1'b1;
                        tbyte   = i_in_byte;
                    end
                end
            end
            S_ESC, S_AFT_HI_BS: begin
                if (i_in_byte == CH_U) begin
                    n_mode = (r_mode == S_ESC) ? S_HEX1 : S_HEX2;
                    n_hex  = '0;
                    n_cnt  = '0;
                end else begin
                    if (r_mode == S_AFT_HI_BS) begin
                        enc = enc16(hi_code);
                    end
                    tail_en = 1'b1;
                    if (esc[8]) begin
                        tbyte  = esc[7:0];
                        n_mode = S_STR;
                    end else begin
                        tkind  = KIND_ERR;
                        n_mode = S_IDLE;
                    end
                end
            end
            S_HEX1, S_HEX2: begin
                if (!dig[4]) begin
                    tail_en = 1'b1;
                    tkind   = KIND_ERR;
                    n_mode  = S_IDLE;
                end else begin
                    n_hex = code[11:0];
                    if (r_cnt == 2'd3) begin
                        n_cnt = '0;
                        if (r_mode == S_HEX1) begin
                            if (code[15:10] == HI_TAG) begin
                                n_high = code[9:0];
                                n_mode = S_AFT_HI;
                            end else begin
                                enc    = enc16(code);
                                n_mode = S_STR;
                            end
                        end else begin
                            if (code[15:10] == LO_TAG) begin
                                enc = enc_pair(r_high, code[9:0]);
                            end else begin
                                enc = enc16(hi_code);
                            end
                            n_high = '0;
                            n_mode = S_STR;
                        end
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
            end
            default: begin
                n_mode = S_IDLE;
            end
        endcase

        // literal still open on the final byte: only an error
        if (i_text_end && n_mode != S_IDLE && !(tail_en && tkind != KIND_BYTE)) begin
            enc     = '0;
            tail_en = 1'b1;
            tkind   = KIND_ERR;
            tbyte   = '0;
            n_mode  = S_IDLE;
        end
        if (n_mode == S_IDLE) begin
            n_hex  = '0;
            n_cnt  = '0;
            n_high = '0;
        end
    end

    always_comb begin
        total             = enc.n + {2'b00, tail_en};
        o_group.data      = enc.b;
        if (tail_en) begin
            o_group.data[enc.n[1:0]] = tbyte;
        end
        o_group.last_idx  = 2'(total - 3'd1);
        o_group.tail_kind = tail_en ? tkind : KIND_BYTE;
        o_push            = accept && (total != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE;
            r_hex  <= '0;
            r_cnt  <= '0;
            r_high <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_cnt  <= n_cnt;
            r_high <= n_high;
        end
    end

endmodule

### hdl/jsud_fifo.sv
// Short queue of result groups between front end and output serializer.
// Depends on jsud_pkg for the group type.
module jsud_fifo #(
    parameter int unsigned DEPTH = jsud_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_valid,
    output logic              o_wr_ready,
    input  jsud_pkg::t_group  i_wr_data,
    output logic              o_rd_valid,
    input  logic              i_rd_ready,
    output jsud_pkg::t_group  o_rd_data
);
    import jsud_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_group          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/jsud_back.sv
// Output serializer: registers one result group and sends its entries
// one per cycle unless stalled, marks the last. Depends on jsud_pkg.
module jsud_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_grp_valid,
    output logic              o_grp_ready,
    input  jsud_pkg::t_group  i_grp,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic [1:0]        o_kind,
    output logic              o_last
);
    import jsud_pkg::*;

    t_group      r_grp;
    logic [1:0]  r_idx;
    logic        r_valid;
    logic        at_last;

    assign at_last     = (r_idx == r_grp.last_idx);
    assign o_out_valid = r_valid;
    assign o_out_byte  = r_grp.data[r_idx];
    assign o_kind      = at_last ? r_grp.tail_kind : KIND_BYTE;
    assign o_last      = at_last;
    assign o_grp_ready = !r_valid || (i_out_ready && at_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_grp_ready) begin
            r_valid <= i_grp_valid;
            r_idx   <= '0;
        end else if (i_out_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_grp_ready) begin
            r_grp <= i_grp;
        end
    end

endmodule

### hdl/json_string_unescape_decoder_unit.sv
// JSON string literal decoder. Takes one source byte per request and gives
// 0 to 4 results per byte (decoded UTF-8 bytes, then possibly a done or
// error marker). A byte is accepted every cycle while the group queue has
// room; results leave the output register one per cycle while i_out_ready
// is high, and the queue of QUEUE_DEPTH groups absorbs bursts from bytes
// with several results, which are stored in the queue, then in the output
// register. Depends on jsud_pkg, jsud_front, jsud_fifo, jsud_back.
module json_string_unescape_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = jsud_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_text_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_kind,
    output logic        o_last
);
    import jsud_pkg::*;

    logic    space;
    logic    push;
    t_group  wr_grp;
    logic    rd_valid;
    logic    rd_ready;
    t_group  rd_grp;

    jsud_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_text_end (i_text_end),
        .i_space    (space),
        .o_push     (push),
        .o_group    (wr_grp)
    );

    jsud_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (push),
        .o_wr_ready (space),
        .i_wr_data  (wr_grp),
        .o_rd_valid (rd_valid),
        .i_rd_ready (rd_ready),
        .o_rd_data  (rd_grp)
    );

    jsud_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (rd_valid),
        .o_grp_ready (rd_ready),
        .i_grp       (rd_grp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_BYTE |-> o_last)
        else $error("done/error marker not last in group");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_BYTE |-> o_out_byte == 8'h00)
        else $error("done/error marker carries data");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> space && i_in_valid)
        else $error("group written without accept or room");

    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule
